FILE: hw/rtl/lbcr_pkg.sv
// Shared types and constants for the line-buffered console receive core.
package lbcr_pkg;

   localparam int BUFFER_DEPTH = 128;
   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_DEPTH);

   localparam int CHAR_W = 7;
   localparam logic [CHAR_W-1:0] CH_LF = 7'h0a;
   localparam logic [CHAR_W-1:0] CH_CR = 7'h0d;
   localparam logic [CHAR_W-1:0] CH_BS = 7'h08;
   localparam logic [CHAR_W-1:0] CH_DEL = 7'h7f;

   typedef enum logic [2:0] {
      OP_RX_BYTE   = 3'd0,
      OP_LINE_READ = 3'd1,
      OP_IMM_READ  = 3'd2,
      OP_RAW_READ  = 3'd3,
      OP_FLUSH     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STS_NONE  = 2'd0,
      STS_EMPTY = 2'd1,
      STS_BYTE  = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_req_type;

endpackage

FILE: hw/rtl/lbcr_char_ram.sv
// Character store: single-port write, registered read.
module lbcr_char_ram
   import lbcr_pkg::*;
(
   input  logic              clock,
   input  ram_req_type       ram_req,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [BUFFER_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/line_buffered_console_rx_core.sv
// Top level of the line-buffered console receive core.
// Usage:
//   req_ channel carries one operation per beat: tuser is the opcode
//   (receive byte, line read, immediate read, raw read, flush), tdata the
//   received byte and break flag. rsp_ channel returns exactly one beat per
//   request: tuser is the read status, tdata the popped byte, LF echo
//   request, line-pending flag, break count and fill level.
//   A beat that pops a byte from the store responds through the registered
//   RAM read and then ST_READ, which loads the response register and advances
//   the head pointer; every other beat's response is registered on acceptance.
//   Non-popping beats are taken one per cycle while rsp_tready is high; a popping
//   beat holds off requests in ST_READ. One request is in flight at a time.
//   The response register is held while rsp_tready is low; a new request is
//   accepted in the cycle the pending response is taken.
//   Reset: synchronous; empties the buffer, clears the line flag and the
//   break counter. Store contents are not cleared, no clearing pass.
module line_buffered_console_rx_core
   import lbcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [6:0] rx_byte, [8] break_seen
   input  logic [2:0]  req_tuser,  // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [6:0] read_byte, [7] echo_lf, [8] line_pending,
                                   // [24:9] breaks_counted, [32:25] fill_level
   output logic [1:0]  rsp_tuser   // [1:0] read_status
);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              line_ff, line_in;
   logic [15:0]       brk_ff, brk_in;
   logic              raw_ff, raw_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [CHAR_W-1:0] byte_ff, byte_in;
   logic              echo_ff, echo_in;

   ram_req_type       ram_req;
   logic [CHAR_W-1:0] rd_data;
   logic              accept;
   op_type            op;
   logic [CHAR_W-1:0] rx;
   logic [CNT_W+7:0]  count_ext;

   lbcr_char_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign op = op_type'(req_tuser);
   assign rx = req_tdata[6:0];

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      line_in = line_ff;
      brk_in = brk_ff;
      raw_in = raw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in = status_ff;
      byte_in = byte_ff;
      echo_in = echo_ff;
      ram_req = '0;
      ram_req.wr_addr = tail_ff;
      ram_req.wr_data = rx;
      ram_req.rd_addr = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in = STS_NONE;
               byte_in = '0;
               echo_in = 1'b0;
               raw_in = (op == OP_RAW_READ);
               unique case (op)
                  OP_RX_BYTE: begin
                     if (req_tdata[8]) begin
                        brk_in = brk_ff + 16'd1;
                     end
                     if (!line_ff && rx != CH_LF) begin
                        if (rx == CH_BS || rx == CH_DEL) begin
                           if (count_ff != '0) begin
                              tail_in = prev_slot(tail_ff);
                              count_in = count_ff - 1'b1;
                           end
                        end else begin
                           if (count_ff < FULL_CNT) begin
                              ram_req.wr_en = 1'b1;
                              tail_in = next_slot(tail_ff);
                              count_in = count_ff + 1'b1;
                           end
                           if (rx == CH_CR) begin
                              line_in = 1'b1;
                           end
                        end
                     end
                  end
                  OP_LINE_READ, OP_IMM_READ, OP_RAW_READ: begin
                     if (op == OP_LINE_READ && !line_ff) begin
                        status_in = STS_NONE;
                     end else if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                        byte_in = (op == OP_LINE_READ) ? CH_CR : '0;
                        line_in = 1'b0;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_req.rd_en = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  OP_FLUSH: begin
                     head_in = '0;
                     tail_in = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            status_in = STS_BYTE;
            byte_in = rd_data;
            echo_in = 1'b0;
            head_in = next_slot(head_ff);
            count_in = count_ff - 1'b1;
            if (!raw_ff && rd_data == CH_CR) begin
               line_in = 1'b0;
               echo_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         line_ff <= 1'b0;
         brk_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         line_ff <= line_in;
         brk_ff <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff <= raw_in;
      status_ff <= status_in;
      byte_ff <= byte_in;
      echo_ff <= echo_in;
   end

   // line flag and counters are sampled live: they only change with a new beat
   assign count_ext = {8'd0, count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {7'd0, count_ext[7:0], brk_ff, line_ff, echo_ff, byte_ff};

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !req_tready)
      else $error("request accepted during store read");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count beyond buffer depth");

   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff && status_ff == STS_BYTE)
      else $error("store read produced no byte response");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty buffer with unequal pointers");

   a_read_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (count_ff != '0))
      else $error("pop from empty buffer");

endmodule
